// ===== src/prc_pkg.sv =====
//------------------------------------------------------------------------------
// Page range cache package
// Shared types, codes and constants of the page range registration cache.
//------------------------------------------------------------------------------
`default_nettype none
package prc_pkg;
	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam logic [4:0] PAGE_SHIFT_RST = 5'd12;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_INSERTED = 3'd2,
		ST_EXISTS   = 3'd3,
		ST_FULL     = 3'd4,
		ST_DROPPED  = 3'd5,
		ST_RELEASED = 3'd6,
		ST_NOTFOUND = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] base_address;
		logic [47:0] buffer_length;
		logic [15:0] endpoint_id;
		logic        match_endpoint;
		logic [31:0] handle_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] handle_out;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} rsp_t;

	typedef struct packed {
		logic [63:0] start_page;
		logic [48:0] page_count;
		logic [31:0] handle;
		logic [15:0] endpoint;
		logic [31:0] references;
	} entry_t;
endpackage
`default_nettype wire

// ===== src/page_range_registration_cache_top.sv =====
//------------------------------------------------------------------------------
// Page range registration cache
// Sorted table of registered page ranges with lookup, insert and delete.
//------------------------------------------------------------------------------
// A request walks the table one entry per step through the single entry
// memory port and the shared two-stage coverage compare, and an insert or
// release then shifts the later entries one at a time. The request side
// stalls until the reply is registered; a reply waits in its register while
// the next request may be offered.
`default_nettype none
module page_range_registration_cache_top #(
	parameter int unsigned TABLE_DEPTH = prc_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire prc_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output prc_pkg::rsp_t      out_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [4:0]    cfg_data
);
	logic [4:0] page_shift_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= prc_pkg::PAGE_SHIFT_RST;
		end else if (cfg_valid) begin
			page_shift_q <= cfg_data;
		end
	end

	prc_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.page_shift(page_shift_q)
	);
endmodule
`default_nettype wire

// ===== src/prc_cover.sv =====
//------------------------------------------------------------------------------
// Page range coverage unit
// Registered two-step check whether a table entry covers a requested range.
//------------------------------------------------------------------------------
`default_nettype none
module prc_cover (
	input  wire logic                  clk,
	input  wire prc_pkg::entry_t       entry,
	input  wire logic [63:0]           paddr,
	input  wire logic [48:0]           pages,
	input  wire logic [4:0]            page_shift,
	output logic                       below_s1,
	output logic                       covers_s2
);
	logic        ok_s1;
	logic [63:0] diff_s1;
	logic [48:0] room_s1;
	logic [63:0] off;

	always_ff @(posedge clk) begin
		below_s1 <= paddr < entry.start_page;
		ok_s1 <= (paddr >= entry.start_page) && (pages <= entry.page_count);
		diff_s1 <= paddr - entry.start_page;
		room_s1 <= entry.page_count - pages;
	end

	assign off = diff_s1 >> page_shift;

	always_ff @(posedge clk) begin
		covers_s2 <= ok_s1 && (off <= {15'd0, room_s1});
	end
endmodule
`default_nettype wire

// ===== src/prc_ctrl.sv =====
//------------------------------------------------------------------------------
// Page range cache sequencer
// Walks, shifts and updates the entry memory one entry per step.
//------------------------------------------------------------------------------
`default_nettype none
module prc_ctrl #(
	parameter int unsigned TABLE_DEPTH = prc_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire prc_pkg::req_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output prc_pkg::rsp_t       out_data,
	input  wire logic [4:0]     page_shift
);
	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PREP  = 9'b000000010,
		S_RD    = 9'b000000100,
		S_WAIT  = 9'b000001000,
		S_CMP   = 9'b000010000,
		S_EVAL  = 9'b000100000,
		S_MVRD  = 9'b001000000,
		S_MVWR  = 9'b010000000,
		S_RESP  = 9'b100000000
	} state_t;

	state_t state_q;
	prc_pkg::req_t req_q;
	logic [63:0] paddr_q;
	logic [48:0] pages_q;
	logic [CW-1:0] used_q, idx_q, mv_q;
	logic [31:0] hit_q, miss_q;
	logic [2:0] status_q;
	logic [31:0] hout_q;
	prc_pkg::entry_t mem_q [TABLE_DEPTH];
	prc_pkg::entry_t rd_q;
	logic [IW-1:0] raddr;
	logic we;
	logic [IW-1:0] waddr;
	prc_pkg::entry_t wdata;
	logic below_s1, covers_s2;
	logic [64:0] psize, sum;
	logic [63:0] pmask;
	logic ep_skip;

	assign psize = 65'd1 << page_shift;
	assign pmask = ~(psize[63:0] - 64'd1);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	prc_cover u_cover (
		.clk(clk), .entry(rd_q), .paddr(paddr_q), .pages(pages_q),
		.page_shift(page_shift), .below_s1(below_s1), .covers_s2(covers_s2)
	);

	assign ep_skip = req_q.match_endpoint && (rd_q.endpoint != req_q.endpoint_id);
	assign sum = {1'b0, req_q.base_address & ~pmask} + {17'd0, req_q.buffer_length}
		+ psize - 65'd1;

	always_comb begin
		raddr = idx_q[IW-1:0];
		if (state_q == S_MVRD) begin
			raddr = (req_q.operation == prc_pkg::OP_INSERT) ?
				IW'(mv_q - CW'(1)) : IW'(mv_q + CW'(1));
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = mv_q[IW-1:0];
		wdata = rd_q;
		if (state_q == S_MVWR) begin
			we = 1'b1;
		end else if (state_q == S_EVAL) begin
			if (req_q.operation == prc_pkg::OP_LOOKUP && covers_s2 && !ep_skip &&
				!below_s1 && idx_q < used_q) begin
				we = 1'b1;
				waddr = idx_q[IW-1:0];
				if (rd_q.references != 32'hFFFF_FFFF) begin
					wdata.references = rd_q.references + 32'd1;
				end
			end else if (req_q.operation == prc_pkg::OP_DELETE && idx_q < used_q &&
				rd_q.handle == req_q.handle_in) begin
				we = 1'b1;
				waddr = idx_q[IW-1:0];
				wdata.references = rd_q.references - 32'd1;
			end
		end else if (state_q == S_RESP && status_q == prc_pkg::ST_INSERTED
			&& !out_valid) begin
			we = 1'b1;
			waddr = idx_q[IW-1:0];
			wdata.start_page = paddr_q;
			wdata.page_count = pages_q;
			wdata.handle = req_q.handle_in;
			wdata.endpoint = req_q.endpoint_id;
			wdata.references = 32'd1;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			hit_q <= '0;
			miss_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			idx_q <= '0;
			mv_q <= '0;
			status_q <= prc_pkg::ST_HIT;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_data.operation != prc_pkg::OP_NONE) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					idx_q <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					if (idx_q >= used_q) begin
						state_q <= S_EVAL;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_CMP;
				S_CMP: state_q <= S_EVAL;
				S_EVAL: begin
					state_q <= S_RESP;
					hout_q <= '0;
					case (req_q.operation)
						prc_pkg::OP_LOOKUP: begin
							if (idx_q >= used_q || below_s1) begin
								status_q <= prc_pkg::ST_MISS;
								miss_q <= miss_q + 32'd1;
							end else if (!ep_skip && covers_s2) begin
								status_q <= prc_pkg::ST_HIT;
								hout_q <= rd_q.handle;
								hit_q <= hit_q + 32'd1;
							end else begin
								idx_q <= idx_q + CW'(1);
								state_q <= S_RD;
							end
						end
						prc_pkg::OP_INSERT: begin
							if (idx_q >= used_q || below_s1) begin
								if (used_q >= CW'(TABLE_DEPTH)) begin
									status_q <= prc_pkg::ST_FULL;
								end else begin
									status_q <= prc_pkg::ST_INSERTED;
									mv_q <= used_q;
									if (used_q != idx_q) begin
										state_q <= S_MVRD;
									end
								end
							end else if (!ep_skip && covers_s2) begin
								status_q <= prc_pkg::ST_EXISTS;
							end else begin
								idx_q <= idx_q + CW'(1);
								state_q <= S_RD;
							end
						end
						default: begin
							if (idx_q >= used_q) begin
								status_q <= prc_pkg::ST_NOTFOUND;
							end else if (rd_q.handle == req_q.handle_in) begin
								if (rd_q.references != 32'd1) begin
									status_q <= prc_pkg::ST_DROPPED;
								end else begin
									status_q <= prc_pkg::ST_RELEASED;
									mv_q <= idx_q;
									if (idx_q + CW'(1) < used_q) begin
										state_q <= S_MVRD;
									end
								end
							end else begin
								idx_q <= idx_q + CW'(1);
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					if (req_q.operation == prc_pkg::OP_INSERT) begin
						mv_q <= mv_q - CW'(1);
						state_q <= (mv_q - CW'(1) == idx_q) ? S_RESP : S_MVRD;
					end else begin
						mv_q <= mv_q + CW'(1);
						state_q <= (mv_q + CW'(2) >= used_q) ? S_RESP : S_MVRD;
					end
				end
				S_RESP: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						out_data.status <= status_q;
						out_data.handle_out <= hout_q;
						out_data.hit_total <= hit_q;
						out_data.miss_total <= miss_q;
						state_q <= S_IDLE;
						if (status_q == prc_pkg::ST_INSERTED) begin
							used_q <= used_q + CW'(1);
						end else if (status_q == prc_pkg::ST_RELEASED) begin
							used_q <= used_q - CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (state_q == S_PREP) begin
			paddr_q <= req_q.base_address & pmask;
			pages_q <= 49'(sum >> page_shift);
		end
	end
endmodule
`default_nettype wire

// ===== src/prc_checker.sv =====
//------------------------------------------------------------------------------
// Page range cache port checker
// Assertions on the top level ports, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module prc_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire prc_pkg::req_t in_data,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire prc_pkg::rsp_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled reply changed");
	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != prc_pkg::ST_HIT |-> out_data.handle_out == 32'd0)
		else $error("handle on non-hit reply");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.operation != prc_pkg::OP_NONE |=> in_stall)
		else $error("took request while busy");
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && out_data.status == prc_pkg::ST_HIT
		|-> out_data.miss_total == $past(out_data.miss_total))
		else $error("miss count moved on hit");
endmodule

bind page_range_registration_cache_top prc_checker u_prc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Page range registration cache testbench
// Drives lookup, insert and delete requests through the stall handshake,
// predicts every reply with an independent model of the sorted range table,
// and compares the replies field by field. Several page sizes are used.
//------------------------------------------------------------------------------
`default_nettype none
module tb_top;
	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 4 * DEPTH + 64;

	typedef struct {
		prc_pkg::req_t    rq;
		bit               typed;
		prc_pkg::status_t st;
		logic [31:0]      hd;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	prc_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	prc_pkg::rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [4:0] cfg_data = '0;

	prc_pkg::entry_t table_model[DEPTH];
	int unsigned used_count;
	logic [31:0] hits_model;
	logic [31:0] misses_model;
	logic [4:0] shift_model;

	prc_pkg::rsp_t pending_rsp[$];
	row_t directed_rows[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit quiet = 1'b0;
	bit insert_heavy = 1'b0;

	always #4 clk = ~clk;

	page_range_registration_cache_top #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	task automatic report(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	function automatic bit range_covers(prc_pkg::entry_t e, logic [63:0] paddr,
			logic [48:0] pages);
		logic [63:0] off;
		if (paddr < e.start_page || pages > e.page_count)
			return 1'b0;
		off = (paddr - e.start_page) >> shift_model;
		return off <= {15'b0, e.page_count - pages};
	endfunction

	function automatic bit cache_predict(prc_pkg::req_t r, output prc_pkg::rsp_t res);
		logic [63:0] psize, paddr;
		logic [65:0] span;
		logic [48:0] pages;
		int i, j;
		bit skip;
		psize = 64'd1 << shift_model;
		paddr = r.base_address & ~(psize - 64'd1);
		span = {2'b0, r.base_address - paddr} + {18'b0, r.buffer_length}
			+ {2'b0, psize} - 66'd1;
		pages = 49'(span >> shift_model);
		res = '0;
		case (prc_pkg::op_t'(r.operation))
			prc_pkg::OP_LOOKUP: begin
				for (i = 0; i < used_count; i++) begin
					if (paddr < table_model[i].start_page)
						break;
					skip = r.match_endpoint && table_model[i].endpoint != r.endpoint_id;
					if (!skip && range_covers(table_model[i], paddr, pages)) begin
						hits_model++;
						if (table_model[i].references != 32'hFFFF_FFFF)
							table_model[i].references++;
						res.status = prc_pkg::ST_HIT;
						res.handle_out = table_model[i].handle;
						res.hit_total = hits_model;
						res.miss_total = misses_model;
						return 1'b1;
					end
				end
				misses_model++;
				res.status = prc_pkg::ST_MISS;
			end
			prc_pkg::OP_INSERT: begin
				res.status = prc_pkg::ST_INSERTED;
				for (i = 0; i < used_count; i++) begin
					if (paddr < table_model[i].start_page)
						break;
					skip = r.match_endpoint && table_model[i].endpoint != r.endpoint_id;
					if (!skip && range_covers(table_model[i], paddr, pages)) begin
						res.status = prc_pkg::ST_EXISTS;
						break;
					end
				end
				if (res.status == prc_pkg::ST_INSERTED) begin
					if (used_count >= DEPTH) begin
						res.status = prc_pkg::ST_FULL;
					end else begin
						for (j = used_count; j > i; j--)
							table_model[j] = table_model[j - 1];
						table_model[i] = '{paddr, pages, r.handle_in, r.endpoint_id, 32'd1};
						used_count++;
					end
				end
			end
			prc_pkg::OP_DELETE: begin
				for (i = 0; i < used_count; i++)
					if (table_model[i].handle == r.handle_in)
						break;
				if (i >= used_count) begin
					res.status = prc_pkg::ST_NOTFOUND;
				end else begin
					table_model[i].references--;
					if (table_model[i].references != 0) begin
						res.status = prc_pkg::ST_DROPPED;
					end else begin
						for (j = i; j + 1 < used_count; j++)
							table_model[j] = table_model[j + 1];
						used_count--;
						res.status = prc_pkg::ST_RELEASED;
					end
				end
			end
			default: return 1'b0;
		endcase
		res.hit_total = hits_model;
		res.miss_total = misses_model;
		return 1'b1;
	endfunction

	task automatic send_request(input prc_pkg::req_t r, input bit typed,
			input prc_pkg::status_t st, input logic [31:0] hd);
		prc_pkg::rsp_t res;
		int gap;
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (cache_predict(r, res)) begin
			if (typed) begin
				res.status = st;
				res.handle_out = hd;
			end
			pending_rsp.push_back(res);
		end
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_page_shift(input logic [4:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shift_model = v;
	endtask

	function automatic prc_pkg::req_t random_request();
		prc_pkg::req_t r;
		int unsigned sel;
		r.operation = 2'($urandom_range(0, 2));
		sel = $urandom_range(0, 99);
		if (insert_heavy)
			r.operation = (sel < 70) ? prc_pkg::OP_INSERT :
				((sel < 85) ? prc_pkg::OP_LOOKUP : prc_pkg::OP_DELETE);
		if ($urandom_range(0, 99) == 0)
			r.operation = prc_pkg::OP_NONE;
		if ($urandom_range(0, 4) == 0) begin
			r.base_address = {$urandom, $urandom};
			r.buffer_length = {16'($urandom), $urandom};
		end else begin
			r.base_address = (64'($urandom_range(0, insert_heavy ? 127 : 47)) << shift_model)
				+ (64'($urandom) & ((64'd1 << shift_model) - 64'd1));
			r.buffer_length = 48'($urandom_range(0, 3)) << shift_model;
			r.buffer_length += 48'($urandom) & ((48'd1 << shift_model) - 48'd1);
		end
		r.endpoint_id = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		r.match_endpoint = $urandom_range(0, 1);
		r.handle_in = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 15));
		if (r.operation == prc_pkg::OP_DELETE && used_count != 0 && $urandom_range(0, 1) == 1)
			r.handle_in = table_model[$urandom_range(0, used_count - 1)].handle;
		return r;
	endfunction

	function automatic void add_row(prc_pkg::op_t op, logic [63:0] a, logic [47:0] l,
			logic [15:0] ep, bit m, logic [31:0] h, bit typed, prc_pkg::status_t st,
			logic [31:0] hd);
		row_t w;
		w.rq = '{op, a, l, ep, m, h};
		w.typed = typed;
		w.st = st;
		w.hd = hd;
		directed_rows.push_back(w);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		prc_pkg::rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected transfer", out_data.handle_out, 32'd0);
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.status != want.status)
					report("status", out_data.status, want.status);
				if (out_data.handle_out != want.handle_out)
					report("handle_out", out_data.handle_out, want.handle_out);
				if (out_data.hit_total != want.hit_total)
					report("hit_total", out_data.hit_total, want.hit_total);
				if (out_data.miss_total != want.miss_total)
					report("miss_total", out_data.miss_total, want.miss_total);
			end
		end
	end

	initial begin
		bit held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!held && cycle_count > 40000) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (800) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				if (!quiet) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [4:0] shifts[5];
		used_count = 0;
		hits_model = '0;
		misses_model = '0;
		shift_model = prc_pkg::PAGE_SHIFT_RST;
		shifts = '{5'd12, 5'd0, 5'd30, 5'd5, 5'd12};

		add_row(prc_pkg::OP_LOOKUP, 64'h1000, 48'h100, 16'd1, 1'b0, 32'h0, 1,
			prc_pkg::ST_MISS, 0);
		add_row(prc_pkg::OP_INSERT, 64'h1000, 48'h2000, 16'd1, 1'b0, 32'hA, 1,
			prc_pkg::ST_INSERTED, 0);
		add_row(prc_pkg::OP_INSERT, 64'h1000, 48'h2000, 16'd1, 1'b0, 32'hC, 1,
			prc_pkg::ST_EXISTS, 0);
		add_row(prc_pkg::OP_LOOKUP, 64'h1800, 48'h10, 16'd1, 1'b1, 32'h0, 1,
			prc_pkg::ST_HIT, 32'hA);
		add_row(prc_pkg::OP_LOOKUP, 64'h1800, 48'h10, 16'd2, 1'b1, 32'h0, 1,
			prc_pkg::ST_MISS, 0);
		add_row(prc_pkg::OP_INSERT, 64'h1000, 48'h2000, 16'd2, 1'b1, 32'hB, 1,
			prc_pkg::ST_INSERTED, 0);
		add_row(prc_pkg::OP_DELETE, 64'h0, 48'h0, 16'd0, 1'b0, 32'hA, 1,
			prc_pkg::ST_DROPPED, 0);
		add_row(prc_pkg::OP_DELETE, 64'h0, 48'h0, 16'd0, 1'b0, 32'hA, 1,
			prc_pkg::ST_RELEASED, 0);
		add_row(prc_pkg::OP_DELETE, 64'h0, 48'h0, 16'd0, 1'b0, 32'hA, 1,
			prc_pkg::ST_NOTFOUND, 0);
		add_row(prc_pkg::OP_NONE, '1, '1, '1, 1'b1, '1, 0, prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_INSERT, '1, '1, '1, 1'b1, '1, 1, prc_pkg::ST_INSERTED, 0);
		add_row(prc_pkg::OP_LOOKUP, '1, 48'h0, '1, 1'b1, 32'h0, 0, prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_LOOKUP, 64'h0, 48'h0, 16'd0, 1'b0, 32'h0, 1,
			prc_pkg::ST_MISS, 0);
		add_row(prc_pkg::OP_INSERT, 64'h0, 48'h0, 16'd0, 1'b0, 32'h0, 1,
			prc_pkg::ST_INSERTED, 0);
		add_row(prc_pkg::OP_LOOKUP, 64'h0, 48'h0, 16'd0, 1'b0, 32'h0, 0,
			prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_INSERT, 64'h5000, 48'h1, 16'd3, 1'b0, 32'h77, 0,
			prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_INSERT, 64'h3000, 48'h1, 16'd3, 1'b0, 32'h77, 0,
			prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_DELETE, 64'h0, 48'h0, 16'd0, 1'b0, 32'h77, 0,
			prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_DELETE, 64'h0, 48'h0, 16'd0, 1'b0, 32'h77, 0,
			prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_DELETE, 64'h0, 48'h0, 16'd0, 1'b0, '1, 0, prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_DELETE, 64'h0, 48'h0, 16'd0, 1'b0, 32'h0, 0,
			prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_DELETE, 64'h0, 48'h0, 16'd0, 1'b0, 32'hB, 0,
			prc_pkg::ST_HIT, 0);
		add_row(prc_pkg::OP_LOOKUP, '1, '1, 16'd0, 1'b0, 32'h0, 0, prc_pkg::ST_HIT, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].st,
				directed_rows[k].hd);

		for (int p = 0; p < 5; p++) begin
			drain_and_settle();
			write_page_shift((p == 3) ? 5'($urandom_range(1, 29)) : shifts[p]);
			insert_heavy = (p == 1) || (p == 2);
			quiet = (p == 4);
			for (int n = 0; n < 240; n++)
				send_request(random_request(), 1'b0, prc_pkg::ST_HIT, 32'd0);
		end

		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
